// ----- design/bicl_pkg.sv -----
`timescale 1ns / 1ps
package bicl_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd1;
  localparam logic [2:0] ST_NAT_OVF    = 3'd2;
  localparam logic [2:0] ST_PITCH_OVF  = 3'd3;
  localparam logic [2:0] ST_BAD_ROW    = 3'd4;
  localparam logic [2:0] ST_BAD_DEPTH  = 3'd5;
  localparam logic [2:0] ST_COPY_LIMIT = 3'd6;
  localparam logic [2:0] ST_SIZE_OVF   = 3'd7;

  // Payload carried beside the width divider.
  typedef struct packed {
    logic [7:0]  bytes_per_block;
    logic [63:0] row_pitch;
    logic [63:0] depth_pitch;
  } wdiv_pay_t;

  // Payload carried beside the height divider.
  typedef struct packed {
    logic [31:0] extent_depth;
    logic [7:0]  block_width;
    logic [7:0]  block_height;
    logic        padded_slices;
    logic        emit_explicit;
  } hdiv_pay_t;

  // Payload carried beside the slice pitch divider.
  typedef struct packed {
    logic [40:0] natural;
    logic [63:0] erp;
    logic [63:0] edp;
    logic [63:0] packed_sz;
    logic [31:0] depth_off;
    logic        padded;
    logic        emit;
    logic        rp_nz;
    logic        dp_nz;
    logic        bad_fmt;
    logic        ovf_pitch;
    logic        bad_row;
    logic        bad_depth;
  } pdiv_pay_t;

  // Payload carried beside the row pitch divider.
  typedef struct packed {
    logic [7:0] block_width;
    logic [7:0] block_height;
  } rdiv_pay_t;

endpackage

// ----- design/bicl_div.sv -----
`timescale 1ns / 1ps
module bicl_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 8,
  parameter int PAY_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [PAY_W-1:0] pay,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic [PAY_W-1:0] pay_out
);

  logic             v_q   [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [PAY_W-1:0] pay_q [NUM_W];

  genvar k;
  for (k = 0; k < NUM_W; k++) begin : g_stage
    logic             v_in;
    logic [NUM_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [PAY_W-1:0] pay_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign nq_in  = num;
      assign rem_in = '0;
      assign den_in = den;
      assign pay_in = pay;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign pay_in = pay_q[k-1];
    end

    assign trial = {rem_in, nq_in[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nq_q[k]  <= {nq_in[NUM_W-2:0], ge};
        rem_q[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        den_q[k] <= den_in;
        pay_q[k] <= pay_in;
      end
    end
  end

  assign out_valid = v_q[NUM_W-1];
  assign quo       = nq_q[NUM_W-1];
  assign rem       = rem_q[NUM_W-1];
  assign pay_out   = pay_q[NUM_W-1];

endmodule

// ----- design/buffer_image_copy_layout.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Payload
// s_axis   in         tdata: extent_width, extent_height, extent_depth, block_width,
//                     block_height, bytes_per_block, row_pitch, depth_pitch
//                     tuser: padded_slices, emit_explicit
// m_axis   out        tdata: status, required_size, row_length, image_height
//
// One request is accepted per cycle while the output is not stalled; the bit-serial
// pipelined dividers have 32 stages for block counts and 64 for the pitches.
// Reset clears only the valid bits of every stage.
// The whole pipeline holds while a finished result waits on m_tready.
module buffer_image_copy_layout (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] extent_width, [63:32] extent_height, [95:64] extent_depth,
  // [103:96] block_width, [111:104] block_height, [119:112] bytes_per_block,
  // [183:120] row_pitch, [247:184] depth_pitch
  input  logic [247:0] s_tdata,
  // [0] padded_slices, [1] emit_explicit
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [2:0] status, [66:3] required_size, [98:67] row_length,
  // [130:99] image_height, [135:131] zero
  output logic [135:0] m_tdata
);
  import bicl_pkg::*;

  logic en;
  logic f_valid;
  assign en       = !f_valid || m_tready;
  assign s_tready = en;

  wdiv_pay_t wp_in, wp_out;
  hdiv_pay_t hp_in, hp_out;
  logic        wx_valid, hx_valid;
  logic [31:0] qx, qy;
  logic [7:0]  rx, ry;

  assign wp_in.bytes_per_block = s_tdata[119:112];
  assign wp_in.row_pitch       = s_tdata[183:120];
  assign wp_in.depth_pitch     = s_tdata[247:184];
  assign hp_in.extent_depth    = s_tdata[95:64];
  assign hp_in.block_width     = s_tdata[103:96];
  assign hp_in.block_height    = s_tdata[111:104];
  assign hp_in.padded_slices   = s_tuser[0];
  assign hp_in.emit_explicit   = s_tuser[1];

  bicl_div #(.NUM_W(32), .DEN_W(8), .PAY_W($bits(wdiv_pay_t))) u_wdiv (
    .clk, .rst, .en,
    .in_valid (s_tvalid && s_tready),
    .num      (s_tdata[31:0]),
    .den      (s_tdata[103:96]),
    .pay      (wp_in),
    .out_valid(wx_valid),
    .quo      (qx),
    .rem      (rx),
    .pay_out  (wp_out)
  );

  bicl_div #(.NUM_W(32), .DEN_W(8), .PAY_W($bits(hdiv_pay_t))) u_hdiv (
    .clk, .rst, .en,
    .in_valid (s_tvalid && s_tready),
    .num      (s_tdata[63:32]),
    .den      (s_tdata[111:104]),
    .pay      (hp_in),
    .out_valid(hx_valid),
    .quo      (qy),
    .rem      (ry),
    .pay_out  (hp_out)
  );

  // Stage A: block counts, natural pitch, effective row pitch.
  logic [32:0] bcx_c, bcy_c;
  logic [40:0] nat_c;
  always_comb begin
    bcx_c = {1'b0, qx} + {32'd0, rx != 8'd0};
    if (bcx_c == 33'd0) begin
      bcx_c = 33'd1;
    end
    bcy_c = {1'b0, qy} + {32'd0, ry != 8'd0};
    if (bcy_c == 33'd0) begin
      bcy_c = 33'd1;
    end
    nat_c = bcx_c * {33'd0, wp_out.bytes_per_block};
  end

  logic        a_valid;
  logic [32:0] a_bcy;
  logic [40:0] a_nat;
  logic [63:0] a_erp, a_dp;
  logic [7:0]  a_bpb, a_bw, a_bh;
  logic [31:0] a_doff;
  logic        a_pad, a_emit, a_rp_nz, a_bad_fmt;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= wx_valid && hx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_bcy     <= bcy_c;
      a_nat     <= nat_c;
      a_erp     <= (wp_out.row_pitch != 64'd0) ? wp_out.row_pitch : {23'd0, nat_c};
      a_dp      <= wp_out.depth_pitch;
      a_bpb     <= wp_out.bytes_per_block;
      a_bw      <= hp_out.block_width;
      a_bh      <= hp_out.block_height;
      a_doff    <= (hp_out.extent_depth == 32'd0) ? 32'd0 : hp_out.extent_depth - 32'd1;
      a_pad     <= hp_out.padded_slices;
      a_emit    <= hp_out.emit_explicit;
      a_rp_nz   <= wp_out.row_pitch != 64'd0;
      a_bad_fmt <= (hp_out.block_width == 8'd0) || (hp_out.block_height == 8'd0) ||
                   (wp_out.bytes_per_block == 8'd0);
    end
  end

  // Stage B: partial products of the packed slice size.
  logic        b_valid;
  logic [64:0] b_pl, b_ph;
  logic [40:0] b_nat;
  logic [63:0] b_erp, b_dp;
  logic [7:0]  b_bpb, b_bw, b_bh;
  logic [31:0] b_doff;
  logic        b_pad, b_emit, b_rp_nz, b_bad_fmt, b_erp_zero, b_bad_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pl       <= {32'd0, a_erp[31:0]} * a_bcy;
      b_ph       <= {32'd0, a_erp[63:32]} * a_bcy;
      b_nat      <= a_nat;
      b_erp      <= a_erp;
      b_dp       <= a_dp;
      b_bpb      <= a_bpb;
      b_bw       <= a_bw;
      b_bh       <= a_bh;
      b_doff     <= a_doff;
      b_pad      <= a_pad;
      b_emit     <= a_emit;
      b_rp_nz    <= a_rp_nz;
      b_bad_fmt  <= a_bad_fmt;
      b_erp_zero <= a_erp == 64'd0;
      b_bad_row  <= a_erp < {23'd0, a_nat};
    end
  end

  // Stage C: packed size, effective slice pitch.
  logic [96:0] packed_c;
  logic [63:0] edp_c;
  assign packed_c = {32'd0, b_pl} + {b_ph, 32'd0};
  assign edp_c    = (b_dp != 64'd0) ? b_dp : packed_c[63:0];

  logic        c_valid;
  logic [63:0] c_erp;
  logic [7:0]  c_bpb;
  pdiv_pay_t   c_pp;
  rdiv_pay_t   c_rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_erp             <= b_erp;
      c_bpb             <= b_bpb;
      c_pp.natural      <= b_nat;
      c_pp.erp          <= b_erp;
      c_pp.edp          <= edp_c;
      c_pp.packed_sz    <= packed_c[63:0];
      c_pp.depth_off    <= b_doff;
      c_pp.padded       <= b_pad;
      c_pp.emit         <= b_emit;
      c_pp.rp_nz        <= b_rp_nz;
      c_pp.dp_nz        <= b_dp != 64'd0;
      c_pp.bad_fmt      <= b_bad_fmt;
      c_pp.ovf_pitch    <= (packed_c[96:64] != 33'd0) || b_erp_zero;
      c_pp.bad_row      <= b_bad_row;
      c_pp.bad_depth    <= edp_c < packed_c[63:0];
      c_rp.block_width  <= b_bw;
      c_rp.block_height <= b_bh;
    end
  end

  logic        pq_valid, rq_valid;
  logic [63:0] iblocks, iblk_rem, rblocks;
  logic [7:0]  rblk_rem;
  pdiv_pay_t   pp;
  rdiv_pay_t   rp;

  bicl_div #(.NUM_W(64), .DEN_W(64), .PAY_W($bits(pdiv_pay_t))) u_pdiv (
    .clk, .rst, .en,
    .in_valid (c_valid),
    .num      (c_pp.edp),
    .den      (c_erp),
    .pay      (c_pp),
    .out_valid(pq_valid),
    .quo      (iblocks),
    .rem      (iblk_rem),
    .pay_out  (pp)
  );

  bicl_div #(.NUM_W(64), .DEN_W(8), .PAY_W($bits(rdiv_pay_t))) u_rdiv (
    .clk, .rst, .en,
    .in_valid (c_valid),
    .num      (c_erp),
    .den      (c_bpb),
    .pay      (c_rp),
    .out_valid(rq_valid),
    .quo      (rblocks),
    .rem      (rblk_rem),
    .pay_out  (rp)
  );

  // Stage D: texel extents, slice offset partial products, size addend.
  logic        d_valid;
  logic [71:0] d_rl, d_ih;
  logic [63:0] d_dl, d_dh;
  logic [64:0] d_addend;
  logic        d_emit, d_rp_nz, d_dp_nz, d_bad_fmt, d_ovf_pitch, d_bad_row, d_bad_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= pq_valid && rq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rl        <= {8'd0, rblocks} * {64'd0, rp.block_width};
      d_ih        <= {8'd0, iblocks} * {64'd0, rp.block_height};
      d_dl        <= {32'd0, pp.depth_off} * {32'd0, pp.edp[31:0]};
      d_dh        <= {32'd0, pp.depth_off} * {32'd0, pp.edp[63:32]};
      d_addend    <= pp.padded ? {1'b0, pp.packed_sz} :
                     {1'b0, pp.packed_sz} - {1'b0, pp.erp} + {24'd0, pp.natural};
      d_emit      <= pp.emit;
      d_rp_nz     <= pp.rp_nz;
      d_dp_nz     <= pp.dp_nz;
      d_bad_fmt   <= pp.bad_fmt;
      d_ovf_pitch <= pp.ovf_pitch;
      d_bad_row   <= pp.bad_row || (rblk_rem != 8'd0);
      d_bad_depth <= pp.bad_depth || (iblk_rem != 64'd0);
    end
  end

  // Stage E: slice offset product, copy limit check.
  logic        e_valid;
  logic [96:0] e_prod;
  logic [64:0] e_addend;
  logic [31:0] e_rl, e_ih;
  logic        e_bad_fmt, e_ovf_pitch, e_bad_row, e_bad_depth, e_bad_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_prod      <= {33'd0, d_dl} + {1'b0, d_dh, 32'd0};
      e_addend    <= d_addend;
      e_rl        <= (d_emit || d_rp_nz) ? d_rl[31:0] : 32'd0;
      e_ih        <= (d_emit || d_dp_nz) ? d_ih[31:0] : 32'd0;
      e_bad_fmt   <= d_bad_fmt;
      e_ovf_pitch <= d_ovf_pitch;
      e_bad_row   <= d_bad_row;
      e_bad_depth <= d_bad_depth;
      e_bad_lim   <= (d_rl[71:32] != 40'd0) || (d_ih[71:32] != 40'd0);
    end
  end

  // Stage F: total size, status priority, output register.
  logic [96:0] total_c;
  logic [2:0]  status_c;
  assign total_c = e_prod + {32'd0, e_addend};

  always_comb begin
    if (e_bad_fmt) begin
      status_c = ST_BAD_FORMAT;
    end else if (e_ovf_pitch) begin
      status_c = ST_PITCH_OVF;
    end else if (e_bad_row) begin
      status_c = ST_BAD_ROW;
    end else if (e_bad_depth) begin
      status_c = ST_BAD_DEPTH;
    end else if (e_bad_lim) begin
      status_c = ST_COPY_LIMIT;
    end else if (total_c[96:64] != 33'd0) begin
      status_c = ST_SIZE_OVF;
    end else begin
      status_c = ST_OK;
    end
  end

  logic [2:0]  f_status;
  logic [63:0] f_size;
  logic [31:0] f_rl, f_ih;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_status <= status_c;
      f_size   <= (status_c == ST_OK) ? total_c[63:0] : 64'd0;
      f_rl     <= (status_c == ST_OK) ? e_rl : 32'd0;
      f_ih     <= (status_c == ST_OK) ? e_ih : 32'd0;
    end
  end

  assign m_tvalid = f_valid;
  assign m_tdata  = {5'd0, f_ih, f_rl, f_size, f_status};

endmodule

// ----- bench/layout_checker.sv -----
`timescale 1ns / 1ps
module layout_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [247:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,
  output int           fail_count,
  output int           pending
);
  import bicl_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] size;
    logic [31:0] row_length;
    logic [31:0] image_height;
  } layout_t;

  layout_t expected_layouts[$];

  function automatic logic [63:0] ceil_div_min1(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    q = n / d + ((n % d) != 0 ? 64'd1 : 64'd0);
    return q == 0 ? 64'd1 : q;
  endfunction

  function automatic layout_t fail_layout(logic [2:0] st);
    layout_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic layout_t compute_layout(logic [247:0] d, logic [1:0] u);
    logic [63:0] ew, eh, ed, bw, bh, bpb, rp, dp, max64;
    logic [63:0] bcx, bcy, natural, erp, packed_sz, edp, rblk, iblk, rl, ih, doff;
    logic [63:0] dbytes, rbytes;
    layout_t r;
    max64 = '1;
    ew = d[31:0];
    eh = d[63:32];
    ed = d[95:64];
    bw = d[103:96];
    bh = d[111:104];
    bpb = d[119:112];
    rp = d[183:120];
    dp = d[247:184];
    if (ed == 0) ed = 1;
    if (bw == 0 || bh == 0 || bpb == 0) return fail_layout(ST_BAD_FORMAT);
    bcx = ceil_div_min1(ew, bw);
    bcy = ceil_div_min1(eh, bh);
    if (bcx > max64 / bpb) return fail_layout(ST_NAT_OVF);
    natural = bcx * bpb;
    erp = rp != 0 ? rp : natural;
    if (erp == 0 || bcy > max64 / erp) return fail_layout(ST_PITCH_OVF);
    if (erp < natural || (erp % bpb) != 0) return fail_layout(ST_BAD_ROW);
    packed_sz = erp * bcy;
    edp = dp != 0 ? dp : packed_sz;
    if (edp < packed_sz || (edp % erp) != 0) return fail_layout(ST_BAD_DEPTH);
    rblk = erp / bpb;
    iblk = edp / erp;
    if (rblk > max64 / bw || iblk > max64 / bh) return fail_layout(ST_COPY_LIMIT);
    rl = rblk * bw;
    ih = iblk * bh;
    if (rl > 64'hFFFF_FFFF || ih > 64'hFFFF_FFFF) return fail_layout(ST_COPY_LIMIT);
    doff = ed - 1;
    r = '0;
    if (u[0]) begin
      if (doff > (max64 - packed_sz) / edp) return fail_layout(ST_SIZE_OVF);
      r.size = edp * doff + packed_sz;
    end else begin
      if (doff > max64 / edp) return fail_layout(ST_SIZE_OVF);
      dbytes = doff * edp;
      rbytes = (bcy - 1) * erp;
      if (dbytes > max64 - rbytes || dbytes + rbytes > max64 - natural)
        return fail_layout(ST_SIZE_OVF);
      r.size = dbytes + rbytes + natural;
    end
    r.status = ST_OK;
    r.row_length = (u[1] || rp != 0) ? rl[31:0] : 32'd0;
    r.image_height = (u[1] || dp != 0) ? ih[31:0] : 32'd0;
    return r;
  endfunction

  assign pending = expected_layouts.size();

  always @(posedge clk) begin
    layout_t want, got;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_layouts.push_back(compute_layout(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[2:0], m_tdata[66:3], m_tdata[98:67], m_tdata[130:99]};
        if (expected_layouts.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_layouts.pop_front();
          if (got !== want || m_tdata[135:131] !== 5'd0) begin
            $display("%0t: mismatch expected st=%0d size=%h rl=%h ih=%h", $time,
                     want.status, want.size, want.row_length, want.image_height);
            $display("%0t:          actual   st=%0d size=%h rl=%h ih=%h", $time,
                     got.status, got.size, got.row_length, got.image_height);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [247:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;
  int           fail_count;
  int           pending;
  int           stall_mode;

  buffer_image_copy_layout i_dut (.*);

  layout_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // The receiver stalls in one of several patterns that change over the run.
  always @(posedge clk) begin
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 1) != 0);
      default: m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_extent();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  task automatic send_request(logic [31:0] ew, eh, ed, logic [7:0] bw, bh, bpb,
                              logic [63:0] rp, dp, logic [1:0] u);
    s_tvalid <= 1'b1;
    s_tdata <= {dp, rp, bpb, bh, bw, ed, eh, ew};
    s_tuser <= u;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Random descriptors: pitches are often a random multiple of the natural ones, else zero or arbitrary.
  task automatic send_random();
    logic [31:0] ew, eh, ed;
    logic [7:0]  bw, bh, bpb;
    logic [63:0] bcx, bcy, rp, dp;
    ew = pick_extent();
    eh = pick_extent();
    ed = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 8);
    bw = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
    bh = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
    bpb = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 16));
    if ($urandom_range(0, 20) == 0) bw = 0;
    bcx = (bw == 0) ? 64'd1 : (64'(ew) + bw - 1) / bw;
    bcy = (bh == 0) ? 64'd1 : (64'(eh) + bh - 1) / bh;
    if (bcx == 0) bcx = 1;
    if (bcy == 0) bcy = 1;
    case ($urandom_range(0, 5))
      0: rp = 0;
      1: rp = rand64();
      2: rp = $urandom_range(0, 2000);
      default: rp = bcx * bpb * $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 5))
      0: dp = 0;
      1: dp = rand64();
      2: dp = $urandom_range(0, 2000);
      default: dp = (rp == 0 ? bcx * bpb : rp) * bcy * $urandom_range(1, 3);
    endcase
    send_request(ew, eh, ed, bw, bh, bpb, rp, dp, 2'($urandom));
  endtask

  initial begin
    int gap;
    stall_mode = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(0, 0, 0, 1, 1, 1, 0, 0, 2'b00);
    send_request(0, 0, 1, 1, 1, 1, 0, 0, 2'b11);
    send_request(4, 4, 1, 0, 4, 16, 0, 0, 2'b00);
    send_request(4, 4, 1, 4, 0, 16, 0, 0, 2'b00);
    send_request(4, 4, 1, 4, 4, 0, 0, 0, 2'b00);
    send_request('1, '1, '1, 1, 1, 255, 0, 0, 2'b01);
    send_request('1, '1, '1, 1, 1, 255, 0, 0, 2'b00);
    send_request(16, 16, 4, 4, 4, 16, 64, 0, 2'b10);
    send_request(16, 16, 4, 4, 4, 16, '1, 0, 2'b00);
    send_request(16, 16, 4, 4, 4, 16, 32, 0, 2'b00);
    send_request(16, 16, 4, 4, 4, 16, 72, 0, 2'b00);
    send_request(16, 16, 4, 4, 4, 16, 64, 100, 2'b00);
    send_request(16, 16, 4, 4, 4, 16, 64, 320, 2'b01);
    send_request(16, 16, 4, 4, 4, 16, 128, 0, 2'b11);
    send_request(8, 8, 2, 1, 1, 1, 64'h1_0000_0000, 0, 2'b00);
    send_request(8, 8, 2, 1, 1, 1, 8, 64'h1_0000_0000 * 8, 2'b00);
    send_request(8, 8, '1, 1, 1, 1, 8, 64'h8000_0000_0000_0000, 2'b01);
    send_request(8, 8, '1, 1, 1, 1, 8, 64'h8000_0000_0000_0000, 2'b00);
    send_request('1, 8, 1, 255, 255, 255, 0, 0, 2'b10);
    send_request(1, 1, 1, 255, 255, 255, '1 - 64'd254, '1 - 64'd254, 2'b11);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1050; n++) begin
      if (n % 150 == 0) stall_mode = $urandom_range(0, 3);
      if (n == 500) begin
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      send_random();
      if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 12);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    stall_mode = 1;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("testbench failed");
    $finish;
  end
endmodule
